// ===== rtl/tgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tgc_pkg: shared types and constants of the touch gesture classifier
// Event codes, configuration register indexes and register widths.
// ----------------------------------------------------------------------------
package tgc_pkg;

  // Width of the threshold registers and of the configuration data port
  localparam int unsigned CfgW = 10;

  // Reset values of the threshold registers
  localparam logic [CfgW-1:0] START_THR_RST = CfgW'(10);
  localparam logic [CfgW-1:0] SWIPE_THR_RST = CfgW'(40);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_START_THR = 1'b0,
    REG_SWIPE_THR = 1'b1
  } cfg_reg_e;

  // Gesture event codes
  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_DRAG        = 3'd1,
    EV_TAP         = 3'd2,
    EV_SWIPE_LEFT  = 3'd3,
    EV_SWIPE_RIGHT = 3'd4,
    EV_SNAP_LEFT   = 3'd5,
    EV_SNAP_RIGHT  = 3'd6
  } event_e;

endpackage

// ===== rtl/touch_gesture_classifier_top.sv =====
// ----------------------------------------------------------------------------
// touch_gesture_classifier_top: tap, swipe and drag classifier
// Tracks press start and last point of touch samples and reports gestures.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one touch sample per
//   transaction: pressed flag and X/Y position. Every sample produces exactly
//   one result transaction on the output channel (out_valid_o / out_ready_i):
//   an event code with X/Y (drag sample or tap point, zero otherwise).
//   Each result is registered in the cycle after its sample; the classifier
//   is a few subtractors and compares between the state and output registers.
//   While the receiver keeps up, throughput is one item per cycle.
//   When the receiver stalls, the output register holds its result and
//   in_ready_o drops until it is taken; a new sample is accepted in the same
//   cycle the pending result leaves.
//   Thresholds are written through cfg_we_i / cfg_addr_i / cfg_wdata_i, by
//   the user only while the block is idle; the block does not enforce it.
//   Reset (rst_ni low, asynchronous) clears the gesture state, empties the
//   output register and loads the default thresholds (start 10, swipe 40).
// ----------------------------------------------------------------------------
module touch_gesture_classifier_top
  import tgc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_addr_i,
  input  logic [CfgW-1:0]       cfg_wdata_i,
  // sample input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  pressed_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  // event output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            event_res_o,
  output logic [COORD_BITS-1:0] event_x_o,
  output logic [COORD_BITS-1:0] event_y_o
);

  // compare width covers both coordinates and thresholds
  localparam int unsigned CmpW = (COORD_BITS > CfgW) ? COORD_BITS : CfgW;

  // threshold registers
  logic [CfgW-1:0] start_thr_q, swipe_thr_q;

  // gesture state
  logic                  was_pressed_q, was_pressed_d;
  logic                  active_q, active_d;
  logic [COORD_BITS-1:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [COORD_BITS-1:0] recent_x_q, recent_x_d, recent_y_q, recent_y_d;
  logic                  horiz_q, horiz_d;
  logic                  vlock_q, vlock_d;

  // output register
  logic                  out_valid_q;
  event_e                ev_q, ev_d;
  logic [COORD_BITS-1:0] ev_x_q, ev_x_d, ev_y_q, ev_y_d;

  logic in_fire;
  logic rise, move, fall;
  logic [CmpW-1:0] adx, ady, travel, start_thr_w, swipe_thr_w;
  logic leftward;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q <= START_THR_RST;
      swipe_thr_q <= SWIPE_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_START_THR: start_thr_q <= cfg_wdata_i;
        REG_SWIPE_THR: swipe_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // distances from the start point
  always_comb begin
    adx = (pos_x_i >= origin_x_q) ? CmpW'(pos_x_i - origin_x_q)
                                  : CmpW'(origin_x_q - pos_x_i);
    ady = (pos_y_i >= origin_y_q) ? CmpW'(pos_y_i - origin_y_q)
                                  : CmpW'(origin_y_q - pos_y_i);
    leftward = recent_x_q < origin_x_q;
    travel = leftward ? CmpW'(origin_x_q - recent_x_q)
                      : CmpW'(recent_x_q - origin_x_q);
    start_thr_w = CmpW'(start_thr_q);
    swipe_thr_w = CmpW'(swipe_thr_q);
  end

  assign rise = pressed_i & ~was_pressed_q;
  assign move = pressed_i & was_pressed_q & active_q;
  assign fall = ~pressed_i & was_pressed_q & active_q;

  // next gesture state and event
  always_comb begin
    was_pressed_d = pressed_i;
    active_d      = active_q;
    origin_x_d    = origin_x_q;
    origin_y_d    = origin_y_q;
    recent_x_d    = recent_x_q;
    recent_y_d    = recent_y_q;
    horiz_d       = horiz_q;
    vlock_d       = vlock_q;
    ev_d          = EV_NONE;
    ev_x_d        = '0;
    ev_y_d        = '0;

    // press-down: latch start point
    if (rise) begin
      active_d   = 1'b1;
      origin_x_d = pos_x_i;
      origin_y_d = pos_y_i;
      horiz_d    = 1'b0;
      vlock_d    = 1'b0;
    end

    if (pressed_i && (rise || active_q)) begin
      recent_x_d = pos_x_i;
      recent_y_d = pos_y_i;
    end

    // motion while held: classify once, then report drag samples in vertical mode
    if (move) begin
      if (!horiz_q && !vlock_q) begin
        if (adx > start_thr_w && adx > ady) begin
          horiz_d = 1'b1;
        end else if (ady > adx && ady > start_thr_w) begin
          vlock_d = 1'b1;
          ev_d    = EV_DRAG;
          ev_x_d  = pos_x_i;
          ev_y_d  = pos_y_i;
        end
      end else if (vlock_q) begin
        ev_d   = EV_DRAG;
        ev_x_d = pos_x_i;
        ev_y_d = pos_y_i;
      end
    end

    // release: swipe, snap-back, tap, or no event after a vertical drag
    if (fall) begin
      active_d = 1'b0;
      if (horiz_q) begin
        if (travel > swipe_thr_w) begin
          ev_d = leftward ? EV_SWIPE_LEFT : EV_SWIPE_RIGHT;
        end else begin
          ev_d = leftward ? EV_SNAP_LEFT : EV_SNAP_RIGHT;
        end
      end else if (!vlock_q) begin
        ev_d   = EV_TAP;
        ev_x_d = recent_x_q;
        ev_y_d = recent_y_q;
      end
      horiz_d = 1'b0;
      vlock_d = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q <= 1'b0;
      active_q      <= 1'b0;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      recent_x_q    <= '0;
      recent_y_q    <= '0;
      horiz_q       <= 1'b0;
      vlock_q       <= 1'b0;
    end else if (in_fire) begin
      was_pressed_q <= was_pressed_d;
      active_q      <= active_d;
      origin_x_q    <= origin_x_d;
      origin_y_q    <= origin_y_d;
      recent_x_q    <= recent_x_d;
      recent_y_q    <= recent_y_d;
      horiz_q       <= horiz_d;
      vlock_q       <= vlock_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q   <= ev_d;
      ev_x_q <= ev_x_d;
      ev_y_q <= ev_y_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign event_x_o   = ev_x_q;
  assign event_y_o   = ev_y_q;

`ifndef SYNTHESIS
  // a result only appears after a sample transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire))
    else $error("result without sample transaction");

  // horizontal swipe and vertical drag are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(horiz_q && vlock_q))
    else $error("both gesture modes set");

  // a mode flag only lives inside an active gesture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (horiz_q || vlock_q) |-> active_q)
    else $error("gesture mode outside active gesture");

  // a release always ends the gesture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && fall) |=> (!active_q && !horiz_q && !vlock_q))
    else $error("gesture not closed on release");
`endif

endmodule
